[hdl/assert_macros.svh]
// Assertion helpers for the modules that check their own logic (here the core).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ZBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ZBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/zbs_pkg.sv]
package zbs_pkg;

	localparam int NUM_ELEM = 4;
	localparam int DIMS_DEF = 4;
	localparam int ELEM_W = 32;
	localparam int BOUND_W = 48;
	localparam int PROD_W = 64;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_DIR_0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DIR_1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIR_2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIR_3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_UNIT_FORM = 3'd4;

	localparam logic signed [BOUND_W-1:0] BOUND_MAX = {1'b0, {(BOUND_W-1){1'b1}}};
	localparam logic signed [BOUND_W-1:0] BOUND_MIN = {1'b1, {(BOUND_W-1){1'b0}}};
	localparam logic signed [PROD_W-1:0] SUP_MAX = {1'b0, {(PROD_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] SUP_MIN = {1'b1, {(PROD_W-1){1'b0}}};

	typedef struct packed {
		logic kind;
		logic signed [ELEM_W-1:0] elem_0;
		logic signed [ELEM_W-1:0] elem_1;
		logic signed [ELEM_W-1:0] elem_2;
		logic signed [ELEM_W-1:0] elem_3;
		logic last;
	} item_t;

	typedef struct packed {
		logic signed [BOUND_W-1:0] lower_0;
		logic signed [BOUND_W-1:0] lower_1;
		logic signed [BOUND_W-1:0] lower_2;
		logic signed [BOUND_W-1:0] lower_3;
		logic signed [BOUND_W-1:0] upper_0;
		logic signed [BOUND_W-1:0] upper_1;
		logic signed [BOUND_W-1:0] upper_2;
		logic signed [BOUND_W-1:0] upper_3;
		logic signed [PROD_W-1:0] support_value;
	} result_t;

	// Stage loads plus what the accumulate stage needs to know about its item.
	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
		logic acc;
		logic clr;
		logic gen;
		logic unit;
	} pipe_ctl_t;

endpackage

[hdl/zbs_lane.sv]
module zbs_lane
	import zbs_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input pipe_ctl_t ctl,
	input logic signed [ELEM_W-1:0] dir,
	input logic signed [ELEM_W-1:0] elem,
	output logic signed [PROD_W-1:0] prod_s1,
	output logic signed [BOUND_W-1:0] low_nxt,
	output logic signed [BOUND_W-1:0] high_nxt
);

	logic signed [ELEM_W-1:0] elem_s1;
	logic signed [ELEM_W-1:0] elem_s2;
	logic signed [ELEM_W-1:0] elem_s3;
	logic signed [BOUND_W-1:0] low_q;
	logic signed [BOUND_W-1:0] high_q;
	logic signed [BOUND_W-1:0] e_ext;
	logic signed [BOUND_W-1:0] e_abs;
	logic signed [BOUND_W-1:0] lo_add;
	logic signed [BOUND_W-1:0] hi_add;
	logic signed [BOUND_W:0] lo_sum;
	logic signed [BOUND_W:0] hi_sum;

	always_ff @(posedge clk) begin
		if (ctl.ld1) begin
			prod_s1 <= PROD_W'(dir) * PROD_W'(elem);
			elem_s1 <= elem;
		end
		if (ctl.ld2) begin
			elem_s2 <= elem_s1;
		end
		if (ctl.ld3) begin
			elem_s3 <= elem_s2;
		end
	end

	always_comb begin
		e_ext = BOUND_W'(elem_s3);
		e_abs = elem_s3[ELEM_W-1] ? -e_ext : e_ext;
		if (!ctl.gen) begin
			lo_add = e_ext;
			hi_add = e_ext;
		end else if (!ctl.unit) begin
			lo_add = -e_abs;
			hi_add = e_abs;
		end else begin
			// In [0,1] form a negative entry only lowers, a positive one only raises.
			lo_add = elem_s3[ELEM_W-1] ? e_ext : '0;
			hi_add = elem_s3[ELEM_W-1] ? '0 : e_ext;
		end
		lo_sum = {low_q[BOUND_W-1], low_q} + {lo_add[BOUND_W-1], lo_add};
		hi_sum = {high_q[BOUND_W-1], high_q} + {hi_add[BOUND_W-1], hi_add};
		if (lo_sum[BOUND_W] != lo_sum[BOUND_W-1]) begin
			low_nxt = lo_sum[BOUND_W] ? BOUND_MIN : BOUND_MAX;
		end else begin
			low_nxt = lo_sum[BOUND_W-1:0];
		end
		if (hi_sum[BOUND_W] != hi_sum[BOUND_W-1]) begin
			high_nxt = hi_sum[BOUND_W] ? BOUND_MIN : BOUND_MAX;
		end else begin
			high_nxt = hi_sum[BOUND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= '0;
			high_q <= '0;
		end else if (ctl.acc) begin
			low_q <= ctl.clr ? '0 : low_nxt;
			high_q <= ctl.clr ? '0 : high_nxt;
		end
	end

endmodule

[hdl/zbs_merge.sv]
module zbs_merge
	import zbs_pkg::*;
#(
	parameter int LANES = DIMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input pipe_ctl_t ctl,
	input logic signed [PROD_W-1:0] prod_s1 [LANES],
	output logic signed [PROD_W-1:0] sup_nxt
);

	logic signed [PROD_W-1:0] term [NUM_ELEM];
	logic signed [PROD_W:0] sum01_s2;
	logic signed [PROD_W:0] sum23_s2;
	logic signed [PROD_W+1:0] total;
	logic signed [PROD_W-1:0] dot_s3;
	logic signed [PROD_W-1:0] sup_q;
	logic signed [PROD_W-1:0] addend;
	logic signed [PROD_W:0] acc_sum;

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_term
		if (i < LANES) begin : g_used
			assign term[i] = prod_s1[i];
		end else begin : g_pad
			assign term[i] = '0;
		end
	end

	always_comb begin
		total = {sum01_s2[PROD_W], sum01_s2} + {sum23_s2[PROD_W], sum23_s2};
	end

	always_ff @(posedge clk) begin
		if (ctl.ld2) begin
			sum01_s2 <= {term[0][PROD_W-1], term[0]} + {term[1][PROD_W-1], term[1]};
			sum23_s2 <= {term[2][PROD_W-1], term[2]} + {term[3][PROD_W-1], term[3]};
		end
		if (ctl.ld3) begin
			// The dot product is exact here and saturates once to 64 bits.
			if (total[PROD_W+1:PROD_W-1] == 3'b000 || total[PROD_W+1:PROD_W-1] == 3'b111) begin
				dot_s3 <= total[PROD_W-1:0];
			end else begin
				dot_s3 <= total[PROD_W+1] ? SUP_MIN : SUP_MAX;
			end
		end
	end

	always_comb begin
		if (!ctl.gen) begin
			addend = dot_s3;
		end else if (!ctl.unit) begin
			if (dot_s3 == SUP_MIN) begin
				addend = SUP_MAX;
			end else begin
				addend = dot_s3[PROD_W-1] ? -dot_s3 : dot_s3;
			end
		end else begin
			addend = dot_s3[PROD_W-1] ? '0 : dot_s3;
		end
		acc_sum = {sup_q[PROD_W-1], sup_q} + {addend[PROD_W-1], addend};
		if (acc_sum[PROD_W] != acc_sum[PROD_W-1]) begin
			sup_nxt = acc_sum[PROD_W] ? SUP_MIN : SUP_MAX;
		end else begin
			sup_nxt = acc_sum[PROD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sup_q <= '0;
		end else if (ctl.acc) begin
			sup_q <= ctl.clr ? '0 : sup_nxt;
		end
	end

endmodule

[hdl/zonotope_box_and_support_core.sv]
// Interval hull and support value of a zonotope, streamed one vector per item.
// Items arrive on item/item_valid/item_stall: a center vector (kind 0) or one
// generator column (kind 1), one Q16.16 element per dimension. An item is
// taken at each edge where item_valid is high and item_stall is low.
// The item marked last closes the zonotope: one result, with all lower and
// upper bounds and the support value, appears on result/result_valid and is
// held until an edge where result_stall is low. Items without last give none.
// Direction and generator form are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high.
// Throughput is one item per cycle while item_stall is low. At the edge
// that takes the last item the lane multipliers load; then the adder tree that
// merges the lane products registers its pair sums and then the saturated
// dot product, and then the accumulators update and the result register loads.
// Items without last keep flowing while a result waits; a last item waits
// in the final stage until the result register is free, and item_stall
// rises once all stages are full and that last item is waiting.
// Reset clears the accumulators, the direction, the form and all valid flags.
`include "assert_macros.svh"

module zonotope_box_and_support_core
	import zbs_pkg::*;
#(
	parameter int DIMS = DIMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output logic result_valid,
	input logic result_stall,
	output result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [REG_IDX_W-1:0] cfg_index,
	input logic [ELEM_W-1:0] cfg_data
);

	localparam int LANES = (DIMS < 1) ? 1 : ((DIMS > NUM_ELEM) ? NUM_ELEM : DIMS);

	logic signed [ELEM_W-1:0] dir_q [NUM_ELEM];
	logic unit_q;
	logic signed [ELEM_W-1:0] elem_in [NUM_ELEM];

	logic valid_s1, valid_s2, valid_s3;
	logic kind_s1, kind_s2, kind_s3;
	logic last_s1, last_s2, last_s3;
	logic unit_s1, unit_s2, unit_s3;
	logic out_free, go3, en1, en2, en3;
	pipe_ctl_t ctl;

	logic signed [PROD_W-1:0] prod_s1 [LANES];
	logic signed [BOUND_W-1:0] low_nxt [LANES];
	logic signed [BOUND_W-1:0] high_nxt [LANES];
	logic signed [BOUND_W-1:0] low_full [NUM_ELEM];
	logic signed [BOUND_W-1:0] high_full [NUM_ELEM];
	logic signed [PROD_W-1:0] sup_nxt;
	logic res_valid_q;
	result_t res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ELEM; i++) begin
				dir_q[i] <= '0;
			end
			unit_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIR_0: dir_q[0] <= cfg_data;
				REG_DIR_1: dir_q[1] <= cfg_data;
				REG_DIR_2: dir_q[2] <= cfg_data;
				REG_DIR_3: dir_q[3] <= cfg_data;
				REG_UNIT_FORM: unit_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign elem_in[0] = item.elem_0;
	assign elem_in[1] = item.elem_1;
	assign elem_in[2] = item.elem_2;
	assign elem_in[3] = item.elem_3;

	always_comb begin
		out_free = !res_valid_q || !result_stall;
		go3 = valid_s3 && (!last_s3 || out_free);
		en3 = !valid_s3 || go3;
		en2 = !valid_s2 || en3;
		en1 = !valid_s1 || en2;
		item_stall = !en1;
		ctl.ld1 = en1;
		ctl.ld2 = en2;
		ctl.ld3 = en3;
		ctl.acc = go3;
		ctl.clr = go3 && last_s3;
		ctl.gen = kind_s3;
		ctl.unit = unit_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= item_valid;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (en3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1 <= item.kind;
			last_s1 <= item.last;
			unit_s1 <= unit_q;
		end
		if (en2) begin
			kind_s2 <= kind_s1;
			last_s2 <= last_s1;
			unit_s2 <= unit_s1;
		end
		if (en3) begin
			kind_s3 <= kind_s2;
			last_s3 <= last_s2;
			unit_s3 <= unit_s2;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		zbs_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.dir(dir_q[i]),
			.elem(elem_in[i]),
			.prod_s1(prod_s1[i]),
			.low_nxt(low_nxt[i]),
			.high_nxt(high_nxt[i])
		);
	end

	for (genvar i = 0; i < NUM_ELEM; i++) begin : g_full
		if (i < LANES) begin : g_used
			assign low_full[i] = low_nxt[i];
			assign high_full[i] = high_nxt[i];
		end else begin : g_zero
			assign low_full[i] = '0;
			assign high_full[i] = '0;
		end
	end

	zbs_merge #(
		.LANES(LANES)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.prod_s1(prod_s1),
		.sup_nxt(sup_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.clr) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			res_q.lower_0 <= low_full[0];
			res_q.lower_1 <= low_full[1];
			res_q.lower_2 <= low_full[2];
			res_q.lower_3 <= low_full[3];
			res_q.upper_0 <= high_full[0];
			res_q.upper_1 <= high_full[1];
			res_q.upper_2 <= high_full[2];
			res_q.upper_3 <= high_full[3];
			res_q.support_value <= sup_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	`ZBS_ASSERT_NOW(a_no_overwrite, clk, arst_n, ctl.clr, out_free, "result overwritten while held")
	`ZBS_ASSERT_NEXT(a_result_follows, clk, arst_n, ctl.clr, result_valid, "last item gave no result")
	`ZBS_ASSERT_NOW(a_acc_valid, clk, arst_n, ctl.acc, valid_s3, "accumulate without an item")
	`ZBS_ASSERT_NOW(a_stall_full, clk, arst_n, item_stall, valid_s1 && valid_s2 && valid_s3, "stall with a free stage")

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import zbs_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_ITEMS = 285;
	localparam int SAT_RUN_LEN = 16;
	localparam int DRAIN_CYCLES = 8;
	localparam logic KIND_CENTER = 1'b0;
	localparam logic KIND_GEN = 1'b1;
	localparam logic signed [ELEM_W-1:0] E_MAX = 32'sh7fffffff;
	localparam logic signed [ELEM_W-1:0] E_MIN = 32'sh80000000;

	// Predicts the bounds and support value of each zonotope and checks the results.
	class zono_scoreboard;
		logic signed [ELEM_W-1:0] dir_q [NUM_ELEM];
		logic unit_q;
		logic signed [BOUND_W-1:0] low_sum [NUM_ELEM];
		logic signed [BOUND_W-1:0] high_sum [NUM_ELEM];
		logic signed [PROD_W-1:0] sup_sum;
		result_t hull_q [$];
		int mismatches;
		int results_seen;

		function new();
			for (int i = 0; i < NUM_ELEM; i++) begin
				dir_q[i] = '0;
				low_sum[i] = '0;
				high_sum[i] = '0;
			end
			unit_q = 1'b0;
			sup_sum = '0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [ELEM_W-1:0] data);
			case (idx)
				REG_DIR_0: dir_q[0] = data;
				REG_DIR_1: dir_q[1] = data;
				REG_DIR_2: dir_q[2] = data;
				REG_DIR_3: dir_q[3] = data;
				REG_UNIT_FORM: unit_q = data[0];
				default: ;
			endcase
		endfunction

		function logic signed [BOUND_W-1:0] add_bound(logic signed [BOUND_W-1:0] a,
				logic signed [BOUND_W+1:0] b);
			logic signed [BOUND_W+1:0] s;
			s = (BOUND_W+2)'(a) + b;
			if (s > (BOUND_W+2)'(BOUND_MAX)) return BOUND_MAX;
			if (s < (BOUND_W+2)'(BOUND_MIN)) return BOUND_MIN;
			return s[BOUND_W-1:0];
		endfunction

		function logic signed [PROD_W-1:0] add_sup(logic signed [PROD_W-1:0] a,
				logic signed [PROD_W+1:0] b);
			logic signed [PROD_W+1:0] s;
			s = (PROD_W+2)'(a) + b;
			if (s > (PROD_W+2)'(SUP_MAX)) return SUP_MAX;
			if (s < (PROD_W+2)'(SUP_MIN)) return SUP_MIN;
			return s[PROD_W-1:0];
		endfunction

		function void note_item(item_t it);
			logic signed [ELEM_W-1:0] e [NUM_ELEM];
			logic signed [PROD_W+2:0] dot_full;
			logic signed [PROD_W-1:0] d;
			logic signed [BOUND_W+1:0] mag;
			result_t r;
			e[0] = it.elem_0;
			e[1] = it.elem_1;
			e[2] = it.elem_2;
			e[3] = it.elem_3;
			// The dot product is formed exactly, then clipped to 64 bits.
			dot_full = '0;
			for (int i = 0; i < DIMS_DEF; i++)
				dot_full = dot_full + (PROD_W+3)'(dir_q[i]) * (PROD_W+3)'(e[i]);
			if (dot_full > (PROD_W+3)'(SUP_MAX))
				d = SUP_MAX;
			else if (dot_full < (PROD_W+3)'(SUP_MIN))
				d = SUP_MIN;
			else
				d = dot_full[PROD_W-1:0];

			if (it.kind == KIND_CENTER) begin
				for (int i = 0; i < DIMS_DEF; i++) begin
					low_sum[i] = add_bound(low_sum[i], (BOUND_W+2)'(e[i]));
					high_sum[i] = add_bound(high_sum[i], (BOUND_W+2)'(e[i]));
				end
				sup_sum = add_sup(sup_sum, (PROD_W+2)'(d));
			end else if (!unit_q) begin
				for (int i = 0; i < DIMS_DEF; i++) begin
					mag = (BOUND_W+2)'(e[i]);
					if (mag < 0)
						mag = -mag;
					low_sum[i] = add_bound(low_sum[i], -mag);
					high_sum[i] = add_bound(high_sum[i], mag);
				end
				if (d == SUP_MIN)
					d = SUP_MAX;
				else if (d < 0)
					d = -d;
				sup_sum = add_sup(sup_sum, (PROD_W+2)'(d));
			end else begin
				for (int i = 0; i < DIMS_DEF; i++) begin
					if (e[i] < 0)
						low_sum[i] = add_bound(low_sum[i], (BOUND_W+2)'(e[i]));
					else
						high_sum[i] = add_bound(high_sum[i], (BOUND_W+2)'(e[i]));
				end
				if (d > 0)
					sup_sum = add_sup(sup_sum, (PROD_W+2)'(d));
			end

			if (it.last) begin
				r.lower_0 = low_sum[0];
				r.lower_1 = low_sum[1];
				r.lower_2 = low_sum[2];
				r.lower_3 = low_sum[3];
				r.upper_0 = high_sum[0];
				r.upper_1 = high_sum[1];
				r.upper_2 = high_sum[2];
				r.upper_3 = high_sum[3];
				r.support_value = sup_sum;
				hull_q = {hull_q, r};
				for (int i = 0; i < NUM_ELEM; i++) begin
					low_sum[i] = '0;
					high_sum[i] = '0;
				end
				sup_sum = '0;
			end
		endfunction

		function void cmp_field(string name, logic [PROD_W-1:0] want, logic [PROD_W-1:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch in %s of result %0d: expected %h, got %h",
						name, results_seen, want, got);
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (hull_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d arrived with none pending: %h", results_seen, got);
				return;
			end
			want = hull_q.pop_front();
			cmp_field("lower_0", PROD_W'(want.lower_0), PROD_W'(got.lower_0));
			cmp_field("lower_1", PROD_W'(want.lower_1), PROD_W'(got.lower_1));
			cmp_field("lower_2", PROD_W'(want.lower_2), PROD_W'(got.lower_2));
			cmp_field("lower_3", PROD_W'(want.lower_3), PROD_W'(got.lower_3));
			cmp_field("upper_0", PROD_W'(want.upper_0), PROD_W'(got.upper_0));
			cmp_field("upper_1", PROD_W'(want.upper_1), PROD_W'(got.upper_1));
			cmp_field("upper_2", PROD_W'(want.upper_2), PROD_W'(got.upper_2));
			cmp_field("upper_3", PROD_W'(want.upper_3), PROD_W'(got.upper_3));
			cmp_field("support_value", want.support_value, got.support_value);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [ELEM_W-1:0] cfg_data = '0;

	zono_scoreboard sb = new();
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left = 0;
	int items_sent = 0;
	int settings_done = 0;
	int cycle_count = 0;

	zonotope_box_and_support_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Handshakes are sampled at the edge, before any update of that edge lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	// A pending hold-off keeps the result side stalled until hold_left counts down to zero.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	function automatic item_t mk_item(logic kind, logic signed [ELEM_W-1:0] e0, e1, e2, e3,
			logic last);
		item_t it;
		it.kind = kind;
		it.elem_0 = e0;
		it.elem_1 = e1;
		it.elem_2 = e2;
		it.elem_3 = e3;
		it.last = last;
		return it;
	endfunction

	function automatic logic signed [ELEM_W-1:0] rand_elem();
		case ($urandom_range(9))
			0: return E_MIN;
			1: return E_MAX;
			2: return '0;
			3, 4: return $signed($urandom_range(131071)) - 65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [ELEM_W-1:0] rand_dir();
		case ($urandom_range(5))
			0: return E_MIN;
			1: return E_MAX;
			2: return '0;
			3: return $signed($urandom_range(262143)) - 131072;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input item_t it);
		if ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic write_setting(input logic [ELEM_W-1:0] d0, d1, d2, d3, input logic form);
		logic [REG_IDX_W-1:0] codes [5];
		logic [ELEM_W-1:0] vals [5];
		codes = '{REG_DIR_0, REG_DIR_1, REG_DIR_2, REG_DIR_3, REG_UNIT_FORM};
		vals = '{d0, d1, d2, d3, {31'd0, form}};
		for (int r = 0; r < 5; r++) begin
			cfg_index <= codes[r];
			cfg_data <= vals[r];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	// Items without last leave no result behind, so a drain wait after the last expected result covers them.
	task automatic wait_drain();
		item_valid <= 1'b0;
		while (sb.hull_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_zonotope();
		int n;
		if ($urandom_range(9) < 8) begin
			n = $urandom_range(1, 8);
			for (int k = 0; k < n; k++)
				send_item(mk_item(k == 0 ? ($urandom_range(9) == 0) : ($urandom_range(9) != 0),
					rand_elem(), rand_elem(), rand_elem(), rand_elem(), k == n - 1));
		end else begin
			// Loose items: any kind, last now and then, sequences left open.
			n = $urandom_range(1, 4);
			for (int k = 0; k < n; k++)
				send_item(mk_item(1'($urandom_range(1)), rand_elem(), rand_elem(), rand_elem(),
					rand_elem(), $urandom_range(2) == 0));
		end
	endtask

	initial begin
		int target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: dot product clipping both ways, the absolute value of the
		// most negative sum, repeated centers, and zonotopes with no center.
		write_setting(E_MIN, E_MIN, E_MIN, E_MIN, 1'b0);
		send_item(mk_item(KIND_CENTER, E_MAX, E_MAX, E_MAX, E_MAX, 1'b0));
		send_item(mk_item(KIND_CENTER, E_MAX, E_MAX, E_MAX, E_MAX, 1'b1));
		send_item(mk_item(KIND_GEN, E_MAX, E_MAX, E_MAX, E_MAX, 1'b1));
		send_item(mk_item(KIND_GEN, E_MIN, E_MIN, E_MIN, E_MIN, 1'b0));
		send_item(mk_item(KIND_GEN, 32'sd1, -32'sd1, 32'sd0, E_MIN, 1'b1));
		send_item(mk_item(KIND_CENTER, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1));
		send_item(mk_item(KIND_CENTER, E_MIN, E_MIN, E_MIN, E_MIN, 1'b0));
		send_item(mk_item(KIND_CENTER, E_MIN, E_MIN, E_MIN, E_MIN, 1'b1));
		wait_drain();
		write_setting(E_MAX, 32'hffffffff, 32'd0, 32'd65536, 1'b1);
		send_item(mk_item(KIND_CENTER, 32'sd65536, -32'sd65536, 32'sd3, E_MAX, 1'b0));
		send_item(mk_item(KIND_GEN, E_MIN, E_MAX, -32'sd1, 32'sd1, 1'b0));
		send_item(mk_item(KIND_GEN, E_MAX, E_MIN, 32'sd0, -32'sd65536, 1'b1));
		send_item(mk_item(KIND_GEN, -32'sd5, 32'sd7, E_MIN, E_MAX, 1'b1));
		send_item(mk_item(KIND_GEN, E_MIN, E_MIN, E_MIN, E_MIN, 1'b1));
		send_item(mk_item(KIND_GEN, E_MAX, E_MAX, E_MAX, E_MAX, 1'b1));
		wait_drain();

		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin tx_idle_pct = 9; rx_idle_pct = 70; end
				1: begin tx_idle_pct = 70; rx_idle_pct = 9; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			case (p)
				0: write_setting(E_MAX, E_MAX, E_MAX, E_MAX, 1'b0);
				1: write_setting(E_MIN, E_MIN, E_MIN, E_MIN, 1'b1);
				2: write_setting(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
				default: write_setting(rand_dir(), rand_dir(), rand_dir(), rand_dir(),
					1'($urandom_range(1)));
			endcase
			// With the sender flat out, a long hold-off fills every stage.
			if (p == 4)
				hold_left = 300;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				send_random_zonotope();
			wait_drain();
		end

		// A run of the most negative generators keeps the support pinned at its maximum.
		write_setting(E_MIN, E_MIN, E_MIN, E_MIN, 1'b0);
		send_item(mk_item(KIND_CENTER, E_MAX, E_MAX, E_MAX, E_MAX, 1'b0));
		for (int k = 0; k < SAT_RUN_LEN; k++)
			send_item(mk_item(KIND_GEN, E_MIN, E_MIN, E_MIN, E_MIN, k == SAT_RUN_LEN - 1));
		wait_drain();

		$display("Run covered %0d items and %0d zonotope results over %0d register settings,",
			items_sent, sb.results_seen, settings_done);
		$display("with idling on either side, a long result hold-off and a saturating run.");
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
